### sv/slipeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slipeu_pkg
// Shared types and constants of the slip hardening Euler update block.
// ----------------------------------------------------------------------------
package slipeu_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_HARDENING_RATE = 3'd0;
  localparam logic [2:0] CFG_INITIAL_HARD   = 3'd1;
  localparam logic [2:0] CFG_SATURATION     = 3'd2;
  localparam logic [2:0] CFG_COEFF_CS       = 3'd3;
  localparam logic [2:0] CFG_COEFF_CX       = 3'd4;
  localparam logic [2:0] CFG_TIME_STEP      = 3'd5;
  localparam logic [2:0] CFG_UPDATE_MODE    = 3'd6;

  // Q24.24 one, saturation bound of intermediates, output limits
  localparam logic [46:0] Q_ONE     = 47'd16777216;
  localparam logic [63:0] BIG       = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] OUT_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OUT_MIN   = 48'h8000_0000_0000;
  localparam logic [63:0] GRAD_GAIN = 64'd50000;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WORK,
    ST_SHEAR,
    ST_WRATE,
    ST_CSQ,
    ST_C50K,
    ST_CDIV,
    ST_READ,
    ST_LOAD,
    ST_V1,
    ST_V2,
    ST_V3,
    ST_G1,
    ST_G2,
    ST_INC,
    ST_EMIT
  } seq_state_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic start;
    logic shift24;   // 1: product >> 24, 0: no shift
    logic cap_full;  // 1: saturate at 2^64-1, 0: saturate at BIG
  } mul_ctrl_t;

endpackage

### sv/slipeu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slipeu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slipeu_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/slipeu_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slipeu_mul
// Shared 64x64 multiplier: four 32x32 partial products, shift and saturate.
// ----------------------------------------------------------------------------
module slipeu_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slipeu_pkg::mul_ctrl_t ctrl_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output logic                  done_o,
  output logic [63:0]           res_o
);

  logic [63:0]  a_q, b_q;
  logic         shift_q, capf_q, busy_q;
  logic [2:0]   cnt_q;
  logic [63:0]  prod_q;
  logic [1:0]   off_q;
  logic [127:0] acc_q;
  logic [31:0]  a_half, b_half;
  logic [127:0] prod_sh, shifted;
  logic [63:0]  cap, res_d;

  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (off_q)
      2'd0:    prod_sh = {64'd0, prod_q};
      2'd1:    prod_sh = {32'd0, prod_q, 32'd0};
      default: prod_sh = {prod_q, 64'd0};
    endcase
  end

  // Shift the full product and saturate
  always_comb begin
    shifted = shift_q ? (acc_q >> 24) : acc_q;
    cap     = capf_q ? {64{1'b1}} : slipeu_pkg::BIG;
    if (shifted[127:64] != 64'd0) begin
      res_d = cap;
    end else if (shifted[63:0] > cap) begin
      res_d = cap;
    end else begin
      res_d = shifted[63:0];
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  // Partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q     <= a_i;
      b_q     <= b_i;
      shift_q <= ctrl_i.shift24;
      capf_q  <= ctrl_i.cap_full;
      acc_q   <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        prod_q <= {32'd0, a_half} * {32'd0, b_half};
        off_q  <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + prod_sh;
      end
      if (cnt_q == 3'd5) begin
        res_o <= res_d;
      end
    end
  end

endmodule

### sv/slipeu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slipeu_div
// Restoring divider, one quotient bit a cycle: min(n * 2^24 / d, BIG).
// ----------------------------------------------------------------------------
module slipeu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  localparam int unsigned Steps = 88;

  logic [63:0] n_q, d_q, r_q, q_q;
  logic        sticky_q, busy_q;
  logic [6:0]  k_q;
  logic [63:0] r_sh, q_sh;
  logic        ge;

  assign r_sh = {r_q[62:0], n_q[63]};
  assign ge   = (r_sh >= d_q);
  assign q_sh = {q_q[62:0], ge};

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= 7'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= 7'd0;
      end else if (busy_q) begin
        if (k_q == 7'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        k_q <= k_q + 7'd1;
      end
    end
  end

  // Shift, compare and subtract; hold a sticky overflow once above the cap
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q      <= n_i;
      d_q      <= d_i;
      r_q      <= 64'd0;
      q_q      <= 64'd0;
      sticky_q <= 1'b0;
    end else if (busy_q) begin
      n_q <= {n_q[62:0], 1'b0};
      r_q <= ge ? (r_sh - d_q) : r_sh;
      if (!sticky_q) begin
        q_q <= q_sh;
        if (q_sh[63:61] != 3'd0) begin
          sticky_q <= 1'b1;
        end
      end
    end
  end

  assign res_o = sticky_q ? slipeu_pkg::BIG : q_q;

endmodule

### sv/slip_hardening_euler_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_hardening_euler_update_top
// Voce hardening law with gradient term, one forward Euler step per grain.
// ----------------------------------------------------------------------------
// Each accepted slip-system request holds the input off for one product on the
// shared multiplier. After the last slip system of a grain the block runs two
// divisions for the shear and work rates (unless the time step is zero) plus,
// when coeff_cx is nonzero, two products and a division on the gradient
// constant; each result then takes a read, a load, three products and a
// division, plus a division and a product when the hardness exceeds the
// initial hardness, and longer while the output is stalled. The iterative
// divider (one quotient bit per cycle over 88 bits) and the shared multiplier
// (four 32x32 partial products) do these. Faulted results (zero time step,
// Voce divisor or c_x) skip them. Register writes are taken only while idle.
// ----------------------------------------------------------------------------
module slip_hardening_euler_update_top #(
  parameter int NUM_SLIP = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slip_increment, back_stress, hardness_prev, hardness_trial (48 bits each)
  input  logic [191:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // hardness_new [47:0], slip_number [51:48], zero fill [55:52]
  output logic [55:0]   m_axis_tdata,
  // div_fault
  output logic          m_axis_tuser,
  output logic          m_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [46:0]   cfg_data_i
);

  localparam int IdxW = (NUM_SLIP > 1) ? $clog2(NUM_SLIP) : 1;
  localparam int CntW = $clog2(NUM_SLIP + 1);

  // Configuration
  logic [46:0] h0_q, tau0_q, sat_q, cs_q, cx_q, ts_q;
  logic        mode_q;

  // Sequencer
  slipeu_pkg::seq_state_e state_q, state_d;
  logic                   issued_q, issued_d;

  // Grain state
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic [55:0]     slip_sum_q;
  logic [63:0]     work_sum_q;
  logic            grain_end_q;

  // Datapath
  logic [47:0] dg_q, tk_q;
  logic [63:0] shear_q, wrate_q, cterm_q, c_q, m_q, voce_q, law_q;
  logic [47:0] prev_q;
  logic [49:0] num1_q, den1_q, diff_q;
  logic [47:0] res_q;
  logic        fault_q;

  // Output register
  logic        m_valid_q;
  logic [47:0] m_hard_q;
  logic [3:0]  m_num_q;
  logic        m_fault_q, m_last_q;

  // Units
  slipeu_pkg::mul_ctrl_t mul_ctrl;
  logic [63:0] mul_a, mul_b, mul_res, div_n, div_d, div_res;
  logic        mul_done, div_done, div_start;

  logic        s_accept, emit_go, last_idx;
  logic [95:0] rd_word;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == slipeu_pkg::ST_IDLE);
  assign cfg_ready_o   = (state_q == slipeu_pkg::ST_IDLE);

  // Store hardness pairs per slip system
  slipeu_ram #(
    .Width(96),
    .Depth(NUM_SLIP)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (s_accept),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i({s_axis_tdata[191:144], s_axis_tdata[143:96]}),
    .raddr_i(idx_q),
    .rdata_o(rd_word)
  );

  slipeu_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mul_ctrl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .done_o(mul_done),
    .res_o (mul_res)
  );

  slipeu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .res_o  (div_res)
  );

  // Operand decode from stored hardness
  logic signed [47:0] rd_prev, rd_trial, tau;
  logic signed [49:0] num1, den1, diff;
  logic               load_fault;
  logic [47:0]        load_res;

  always_comb begin
    rd_prev  = rd_word[47:0];
    rd_trial = rd_word[95:48];
    tau      = mode_q ? rd_trial : rd_prev;
    num1     = $signed({3'd0, sat_q}) - 50'(tau);
    den1     = $signed({3'd0, sat_q}) - $signed({3'd0, tau0_q});
    diff     = 50'(tau) - $signed({3'd0, tau0_q});
    load_fault = 1'b1;
    load_res   = slipeu_pkg::OUT_MAX;
    if (ts_q == 47'd0) begin
      load_res = slipeu_pkg::OUT_MAX;
    end else if (den1 == 50'sd0) begin
      load_res = num1[49] ? slipeu_pkg::OUT_MIN : slipeu_pkg::OUT_MAX;
    end else if (diff > 50'sd0 && cx_q == 47'd0) begin
      load_res = slipeu_pkg::OUT_MAX;
    end else begin
      load_fault = 1'b0;
    end
  end

  // Magnitudes of signed operands
  logic [49:0] num1_mag, den1_mag;
  logic [63:0] law_mag;
  assign num1_mag = num1_q[49] ? (50'd0 - num1_q) : num1_q;
  assign den1_mag = den1_q[49] ? (50'd0 - den1_q) : den1_q;
  assign law_mag  = law_q[63] ? (64'd0 - law_q) : law_q;

  // Steer operands to the shared units
  always_comb begin
    mul_a = 64'd0;
    mul_b = 64'd0;
    div_n = 64'd0;
    div_d = 64'd1;
    case (state_q)
      slipeu_pkg::ST_WORK: begin
        mul_a = {16'd0, dg_q};
        mul_b = {16'd0, tk_q};
      end
      slipeu_pkg::ST_CSQ: begin
        mul_a = {17'd0, cs_q};
        mul_b = {17'd0, cs_q};
      end
      slipeu_pkg::ST_C50K: begin
        mul_a = c_q;
        mul_b = slipeu_pkg::GRAD_GAIN;
      end
      slipeu_pkg::ST_V1: begin
        mul_a = {17'd0, h0_q};
        mul_b = {14'd0, num1_mag};
      end
      slipeu_pkg::ST_V3: begin
        mul_a = m_q;
        mul_b = shear_q;
      end
      slipeu_pkg::ST_G2: begin
        mul_a = c_q;
        mul_b = wrate_q;
      end
      slipeu_pkg::ST_INC: begin
        mul_a = {17'd0, ts_q};
        mul_b = law_mag;
      end
      slipeu_pkg::ST_SHEAR: begin
        div_n = {8'd0, slip_sum_q};
        div_d = {17'd0, ts_q};
      end
      slipeu_pkg::ST_WRATE: begin
        div_n = work_sum_q;
        div_d = {17'd0, ts_q};
      end
      slipeu_pkg::ST_CDIV: begin
        div_n = c_q;
        div_d = {16'd0, cx_q, 1'b0};
      end
      slipeu_pkg::ST_V2: begin
        div_n = m_q;
        div_d = {14'd0, den1_mag};
      end
      slipeu_pkg::ST_G1: begin
        div_n = cterm_q;
        div_d = {14'd0, diff_q};
      end
      default: begin
      end
    endcase
  end

  assign emit_go  = (state_q == slipeu_pkg::ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign last_idx = ((CntW'(idx_q) + CntW'(1)) == count_q);

  // Next state and unit requests
  always_comb begin
    state_d           = state_q;
    issued_d          = issued_q;
    mul_ctrl.start    = 1'b0;
    mul_ctrl.shift24  = (state_q != slipeu_pkg::ST_C50K);
    mul_ctrl.cap_full = (state_q == slipeu_pkg::ST_WORK);
    div_start         = 1'b0;
    case (state_q)
      slipeu_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = slipeu_pkg::ST_WORK;
        end
      end
      slipeu_pkg::ST_WORK, slipeu_pkg::ST_CSQ, slipeu_pkg::ST_C50K,
      slipeu_pkg::ST_V1, slipeu_pkg::ST_V3, slipeu_pkg::ST_G2,
      slipeu_pkg::ST_INC: begin
        if (!issued_q) begin
          mul_ctrl.start = 1'b1;
          issued_d       = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          case (state_q)
            slipeu_pkg::ST_WORK: begin
              if (!grain_end_q) begin
                state_d = slipeu_pkg::ST_IDLE;
              end else if (ts_q == 47'd0) begin
                state_d = slipeu_pkg::ST_READ;
              end else begin
                state_d = slipeu_pkg::ST_SHEAR;
              end
            end
            slipeu_pkg::ST_CSQ:  state_d = slipeu_pkg::ST_C50K;
            slipeu_pkg::ST_C50K: state_d = slipeu_pkg::ST_CDIV;
            slipeu_pkg::ST_V1:   state_d = slipeu_pkg::ST_V2;
            slipeu_pkg::ST_V3: begin
              state_d = diff_q[49] || (diff_q == 50'd0) ? slipeu_pkg::ST_INC
                                                        : slipeu_pkg::ST_G1;
            end
            slipeu_pkg::ST_G2:   state_d = slipeu_pkg::ST_INC;
            default:             state_d = slipeu_pkg::ST_EMIT;
          endcase
        end
      end
      slipeu_pkg::ST_SHEAR, slipeu_pkg::ST_WRATE, slipeu_pkg::ST_CDIV,
      slipeu_pkg::ST_V2, slipeu_pkg::ST_G1: begin
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          case (state_q)
            slipeu_pkg::ST_SHEAR: state_d = slipeu_pkg::ST_WRATE;
            slipeu_pkg::ST_WRATE: begin
              state_d = (cx_q == 47'd0) ? slipeu_pkg::ST_READ : slipeu_pkg::ST_CSQ;
            end
            slipeu_pkg::ST_CDIV:  state_d = slipeu_pkg::ST_READ;
            slipeu_pkg::ST_V2:    state_d = slipeu_pkg::ST_V3;
            default:              state_d = slipeu_pkg::ST_G2;
          endcase
        end
      end
      slipeu_pkg::ST_READ: state_d = slipeu_pkg::ST_LOAD;
      slipeu_pkg::ST_LOAD: begin
        state_d = load_fault ? slipeu_pkg::ST_EMIT : slipeu_pkg::ST_V1;
      end
      slipeu_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = last_idx ? slipeu_pkg::ST_IDLE : slipeu_pkg::ST_READ;
        end
      end
      default: state_d = slipeu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slipeu_pkg::ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q   <= 47'd0;
      tau0_q <= 47'd0;
      sat_q  <= 47'd0;
      cs_q   <= 47'd0;
      cx_q   <= slipeu_pkg::Q_ONE;
      ts_q   <= slipeu_pkg::Q_ONE;
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        slipeu_pkg::CFG_HARDENING_RATE: h0_q   <= cfg_data_i;
        slipeu_pkg::CFG_INITIAL_HARD:   tau0_q <= cfg_data_i;
        slipeu_pkg::CFG_SATURATION:     sat_q  <= cfg_data_i;
        slipeu_pkg::CFG_COEFF_CS:       cs_q   <= cfg_data_i;
        slipeu_pkg::CFG_COEFF_CX:       cx_q   <= cfg_data_i;
        slipeu_pkg::CFG_TIME_STEP:      ts_q   <= cfg_data_i;
        slipeu_pkg::CFG_UPDATE_MODE:    mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Accumulate sums, count slip systems, advance the result index
  logic [47:0] dg_in, tk_in;
  logic [56:0] slip_add;
  logic [64:0] work_add;
  assign dg_in    = s_axis_tdata[47]  ? (48'd0 - s_axis_tdata[47:0])  : s_axis_tdata[47:0];
  assign tk_in    = s_axis_tdata[95]  ? (48'd0 - s_axis_tdata[95:48]) : s_axis_tdata[95:48];
  assign slip_add = {1'b0, slip_sum_q} + {9'd0, dg_in};
  assign work_add = {1'b0, work_sum_q} + {1'b0, mul_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      slip_sum_q  <= 56'd0;
      work_sum_q  <= 64'd0;
      grain_end_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (s_accept) begin
        count_q     <= count_q + CntW'(1);
        grain_end_q <= s_axis_tlast || ((count_q + CntW'(1)) == CntW'(NUM_SLIP));
        slip_sum_q  <= slip_add[56] ? {56{1'b1}} : slip_add[55:0];
      end
      if (state_q == slipeu_pkg::ST_WORK && issued_q && mul_done) begin
        work_sum_q <= work_add[64] ? {64{1'b1}} : work_add[63:0];
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
        if (last_idx) begin
          idx_q      <= '0;
          count_q    <= '0;
          slip_sum_q <= 56'd0;
          work_sum_q <= 64'd0;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold operands and intermediate results
  logic signed [63:0] hard_sum;
  assign hard_sum = 64'(signed'(prev_q)) + (law_q[63] ? (64'd0 - mul_res) : mul_res);

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      dg_q <= dg_in;
      tk_q <= tk_in;
    end
    if (mul_done) begin
      case (state_q)
        slipeu_pkg::ST_CSQ:  c_q <= mul_res;
        slipeu_pkg::ST_C50K: c_q <= mul_res;
        slipeu_pkg::ST_V1:   m_q <= mul_res;
        slipeu_pkg::ST_V3: begin
          voce_q <= (num1_q[49] ^ den1_q[49]) ? (64'd0 - mul_res) : mul_res;
          law_q  <= (num1_q[49] ^ den1_q[49]) ? (64'd0 - mul_res) : mul_res;
        end
        slipeu_pkg::ST_G2:   law_q <= voce_q + mul_res;
        slipeu_pkg::ST_INC: begin
          fault_q <= 1'b0;
          if (hard_sum > 64'(signed'(slipeu_pkg::OUT_MAX))) begin
            res_q <= slipeu_pkg::OUT_MAX;
          end else if (hard_sum < 64'(signed'(slipeu_pkg::OUT_MIN))) begin
            res_q <= slipeu_pkg::OUT_MIN;
          end else begin
            res_q <= hard_sum[47:0];
          end
        end
        default: begin
        end
      endcase
    end
    if (div_done) begin
      case (state_q)
        slipeu_pkg::ST_SHEAR: shear_q <= div_res;
        slipeu_pkg::ST_WRATE: wrate_q <= div_res;
        slipeu_pkg::ST_CDIV:  cterm_q <= div_res;
        slipeu_pkg::ST_V2:    m_q     <= div_res;
        slipeu_pkg::ST_G1:    c_q     <= div_res;
        default: begin
        end
      endcase
    end
    if (state_q == slipeu_pkg::ST_LOAD) begin
      prev_q  <= rd_prev;
      num1_q  <= num1;
      den1_q  <= den1;
      diff_q  <= diff;
      fault_q <= load_fault;
      res_q   <= load_res;
    end
    if (emit_go) begin
      m_hard_q  <= res_q;
      m_num_q   <= 4'({4'd0, idx_q});
      m_fault_q <= fault_q;
      m_last_q  <= last_idx;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_num_q, m_hard_q};
  assign m_axis_tuser  = m_fault_q;
  assign m_axis_tlast  = m_last_q;

  // Only one shared unit is ever busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  // The slip count stays inside the store while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slipeu_pkg::ST_IDLE) |-> (count_q < CntW'(NUM_SLIP)))
    else $error("slip count beyond store depth");

  // The final result of a grain clears the grain state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && last_idx) |=> (count_q == '0 && slip_sum_q == 56'd0 && idx_q == '0))
    else $error("grain state not cleared after final result");

  // A new request is only taken when no result sequence is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |-> (idx_q == '0))
    else $error("request taken during result sequence");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slip hardening Euler update block. Slip-system
// requests are streamed in grains under changing register settings, with
// random gaps on both stream sides and one long receiver hold-off. A local
// hardness predictor computes the untyped results; all are compared field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  SLIPS   = 12;
  localparam int  WD_MAX  = 20000;
  localparam int  HOLD_LEN = 1500;
  localparam longint QV   = 64'sd16777216;
  localparam logic [63:0] M56 = (64'd1 << 56) - 1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [46:0] val;
    logic [47:0] slip, back, prev, trial;
    logic        last;
    int          rep;
    logic        typed;
    logic [47:0] exp_h;
    logic        exp_f;
  } stim_row_t;

  typedef struct {
    logic [47:0] h;
    logic [3:0]  n;
    logic        f;
    logic        l;
  } hard_res_t;

  logic          clk_i, rst_ni;
  logic [191:0]  s_axis_tdata;
  logic          s_axis_tlast, s_axis_tvalid, s_axis_tready;
  logic [55:0]   m_axis_tdata;
  logic          m_axis_tuser, m_axis_tlast, m_axis_tvalid, m_axis_tready;
  logic          cfg_valid_i, cfg_ready_o;
  logic [2:0]    cfg_index_i;
  logic [46:0]   cfg_data_i;

  // predictor copy of registers and grain state
  logic [63:0] r_h0, r_tau0, r_sat, r_cs, r_cx, r_dt;
  logic        r_mode;
  longint      prev_mem [SLIPS];
  longint      trial_mem[SLIPS];
  logic [63:0] slip_acc, work_acc;
  int          slip_cnt;

  hard_res_t   hardness_q[$];
  stim_row_t   dir_tab[$];
  int          errors, n_items, n_results, n_grains, wd_cnt, stall_left, hold_left;
  logic        hold_req, hold_done;

  slip_hardening_euler_update_top #(.NUM_SLIP(SLIPS)) u_dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tlast, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int sh,
                                          logic [63:0] cap);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] div_cap(logic [63:0] n, logic [63:0] d, logic [63:0] cap);
    logic [127:0] q;
    q = {40'd0, n, 24'd0} / {64'd0, d};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] mag_of(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [47:0] hardness_calc(int i, output logic fault);
    longint prev, tau, tau0, satv, num1, den1, diff, law, res;
    logic [63:0] shear, work, m, c, inc;
    prev = prev_mem[i];
    tau  = r_mode ? trial_mem[i] : prev;
    tau0 = longint'(r_tau0);
    satv = longint'(r_sat);
    num1 = satv - tau;
    den1 = satv - tau0;
    diff = tau - tau0;
    fault = 1'b1;
    if (r_dt == 0) return slipeu_pkg::OUT_MAX;
    if (den1 == 0) return (num1 >= 0) ? slipeu_pkg::OUT_MAX : slipeu_pkg::OUT_MIN;
    if (diff > 0 && r_cx == 0) return slipeu_pkg::OUT_MAX;
    fault = 1'b0;
    shear = div_cap(slip_acc, r_dt, slipeu_pkg::BIG);
    work  = div_cap(work_acc, r_dt, slipeu_pkg::BIG);
    // Voce term toward saturation
    m = mul_cap(r_h0, mag_of(num1), 24, slipeu_pkg::BIG);
    m = div_cap(m, mag_of(den1), slipeu_pkg::BIG);
    m = mul_cap(m, shear, 24, slipeu_pkg::BIG);
    law = ((num1 < 0) != (den1 < 0)) ? -longint'(m) : longint'(m);
    // gradient term only above the initial hardness
    if (diff > 0) begin
      c = mul_cap(r_cs, r_cs, 24, slipeu_pkg::BIG);
      c = mul_cap(c, slipeu_pkg::GRAD_GAIN, 0, slipeu_pkg::BIG);
      c = div_cap(c, 2 * r_cx, slipeu_pkg::BIG);
      c = div_cap(c, 64'(diff), slipeu_pkg::BIG);
      c = mul_cap(c, work, 24, slipeu_pkg::BIG);
      law = law + longint'(c);
    end
    inc = mul_cap(r_dt, mag_of(law), 24, slipeu_pkg::BIG);
    res = prev + ((law < 0) ? -longint'(inc) : longint'(inc));
    if (res > longint'(slipeu_pkg::OUT_MAX)) res = longint'(slipeu_pkg::OUT_MAX);
    if (res < -(64'sd1 <<< 47)) res = -(64'sd1 <<< 47);
    return res[47:0];
  endfunction

  // Advance the predictor by one accepted request; fill res with grain results
  task automatic hardness_step(logic [191:0] d, logic last, ref hard_res_t res[$]);
    logic [63:0] dg, tk, w;
    hard_res_t   r;
    dg = mag_of(longint'(signed'(d[47:0])));
    tk = mag_of(longint'(signed'(d[95:48])));
    res.delete();
    if (slip_cnt >= SLIPS) slip_cnt = 0;
    prev_mem[slip_cnt]  = longint'(signed'(d[143:96]));
    trial_mem[slip_cnt] = longint'(signed'(d[191:144]));
    slip_cnt++;
    slip_acc = slip_acc + dg;
    if (slip_acc > M56) slip_acc = M56;
    w = mul_cap(dg, tk, 24, '1);
    work_acc = (work_acc > ~w) ? '1 : work_acc + w;
    if (!last && slip_cnt < SLIPS) return;
    for (int i = 0; i < slip_cnt; i++) begin
      r.h = hardness_calc(i, r.f);
      r.n = 4'(i);
      r.l = (i + 1 == slip_cnt);
      res.push_back(r);
    end
    slip_acc = '0;
    work_acc = '0;
    slip_cnt = 0;
  endtask

  // ------------------------------------------------------------------- drivers
  task automatic cfg_write(logic [2:0] idx, logic [46:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      slipeu_pkg::CFG_HARDENING_RATE: r_h0   = {17'd0, val};
      slipeu_pkg::CFG_INITIAL_HARD:   r_tau0 = {17'd0, val};
      slipeu_pkg::CFG_SATURATION:     r_sat  = {17'd0, val};
      slipeu_pkg::CFG_COEFF_CS:       r_cs   = {17'd0, val};
      slipeu_pkg::CFG_COEFF_CX:       r_cx   = {17'd0, val};
      slipeu_pkg::CFG_TIME_STEP:      r_dt   = {17'd0, val};
      slipeu_pkg::CFG_UPDATE_MODE:    r_mode = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Hold until every expected result is out, then let the block settle
  task automatic wait_idle();
    while (hardness_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // Offer one request; typed rows replace the predicted results
  task automatic send_slip(logic [47:0] sl, logic [47:0] bk, logic [47:0] pv,
                           logic [47:0] tr, logic last, logic typed,
                           logic [47:0] eh, logic ef);
    hard_res_t res[$];
    hard_res_t t;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tr, pv, bk, sl};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    hardness_step({tr, pv, bk, sl}, last, res);
    if (res.size() != 0) n_grains++;
    if (typed) begin
      t.h = eh; t.n = 4'd0; t.f = ef; t.l = 1'b1;
      hardness_q.push_back(t);
    end else begin
      foreach (res[k]) hardness_q.push_back(res[k]);
    end
    if ($urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  function automatic logic [47:0] qv(int x);
    return 48'(longint'(x) * QV);
  endfunction

  function automatic logic [47:0] rnd_field();
    case ($urandom_range(0, 7))
      0: return 48'({$urandom(), $urandom()});
      1: return 48'(longint'($urandom_range(0, 200)) * QV / 2 - 50 * QV);
      default: return 48'($urandom_range(0, 32'h7FFF_FFFF)) - 48'h3FFF_FFFF;
    endcase
  endfunction

  function automatic logic [46:0] rnd_reg(int hi_units);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return 47'(longint'($urandom_range(0, hi_units * 256)) * QV / 256);
  endfunction

  task automatic cfg_row(logic [2:0] idx, logic [46:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.idx = idx; r.val = val;
    dir_tab.push_back(r);
  endtask

  task automatic item_row(logic [47:0] sl, logic [47:0] bk, logic [47:0] pv,
                          logic [47:0] tr, logic last, int rep, logic typed,
                          logic [47:0] eh, logic ef);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.slip = sl; r.back = bk; r.prev = pv; r.trial = tr;
    r.last = last; r.rep = rep; r.typed = typed; r.exp_h = eh; r.exp_f = ef;
    dir_tab.push_back(r);
  endtask

  // ------------------------------------------------------- result receiver
  always @(posedge clk_i) begin
    hard_res_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (hardness_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = hardness_q.pop_front();
        if (m_axis_tdata[47:0] !== e.h || m_axis_tdata[51:48] !== e.n ||
            m_axis_tuser !== e.f || m_axis_tlast !== e.l) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp h=%h n=%0d f=%b l=%b, got h=%h n=%0d f=%b l=%b",
                     e.h, e.n, e.f, e.l, m_axis_tdata[47:0], m_axis_tdata[51:48],
                     m_axis_tuser, m_axis_tlast);
        end
      end
    end
    // stall pattern, with one long hold-off on request
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // Watchdog on cycles without any handshake on the request, result or register ports
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wd_cnt = 0;
    end else if (++wd_cnt >= WD_MAX) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------- main flow
  initial begin
    int glen;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    errors = 0; n_items = 0; n_results = 0; n_grains = 0; wd_cnt = 0;
    stall_left = 0; hold_left = 0; hold_req = 1'b0; hold_done = 1'b0;
    r_h0 = '0; r_tau0 = '0; r_sat = '0; r_cs = '0; r_cx = QV; r_dt = QV; r_mode = 1'b0;
    slip_acc = '0; work_acc = '0; slip_cnt = 0;
    foreach (prev_mem[i]) begin prev_mem[i] = 0; trial_mem[i] = 0; end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset saturation equals initial hardness: Voce divisor is zero
    item_row(qv(1), qv(2), qv(5),  qv(0), 1'b1, 1, 1'b1, slipeu_pkg::OUT_MIN, 1'b1);
    item_row(qv(1), qv(2), -qv(3), qv(0), 1'b1, 1, 1'b1, slipeu_pkg::OUT_MAX, 1'b1);
    item_row(qv(0), qv(0), qv(0),  qv(0), 1'b1, 1, 1'b1, slipeu_pkg::OUT_MAX, 1'b1);
    // zero time step
    cfg_row(slipeu_pkg::CFG_TIME_STEP, '0);
    item_row(qv(1), qv(1), qv(1), qv(1), 1'b1, 1, 1'b1, slipeu_pkg::OUT_MAX, 1'b1);
    // zero c_x above and below the initial hardness
    cfg_row(slipeu_pkg::CFG_TIME_STEP, slipeu_pkg::Q_ONE);
    cfg_row(slipeu_pkg::CFG_SATURATION, 47'(qv(100)));
    cfg_row(slipeu_pkg::CFG_INITIAL_HARD, 47'(qv(10)));
    cfg_row(slipeu_pkg::CFG_HARDENING_RATE, 47'(qv(2)));
    cfg_row(slipeu_pkg::CFG_COEFF_CS, 47'(qv(1)) >> 1);
    cfg_row(slipeu_pkg::CFG_COEFF_CX, '0);
    item_row(qv(1), qv(3), qv(20), qv(0), 1'b1, 1, 1'b1, slipeu_pkg::OUT_MAX, 1'b1);
    item_row(qv(1), qv(3), qv(5),  qv(0), 1'b1, 1, 1'b0, '0, 1'b0);
    // ordinary grain with field extremes
    cfg_row(slipeu_pkg::CFG_COEFF_CX, slipeu_pkg::Q_ONE);
    item_row(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, qv(20), qv(30), 1'b0, 1, 1'b0, '0, 1'b0);
    item_row(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
             48'h8000_0000_0000, 1'b0, 1, 1'b0, '0, 1'b0);
    item_row(qv(1) >> 4, qv(50), 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b1, 1,
             1'b0, '0, 1'b0);
    // law at trial hardness
    cfg_row(slipeu_pkg::CFG_UPDATE_MODE, 47'd1);
    item_row(-(qv(1) >> 3), qv(40), qv(12), qv(60), 1'b0, 1, 1'b0, '0, 1'b0);
    item_row(qv(1) >> 2, -qv(40), qv(60), qv(5), 1'b1, 1, 1'b0, '0, 1'b0);
    // a full grain without a closing flag ends on the count
    item_row(qv(1) >> 5, qv(30), qv(15), qv(25), 1'b0, SLIPS, 1'b0, '0, 1'b0);
    cfg_row(slipeu_pkg::CFG_UPDATE_MODE, '0);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_write(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        for (int k = 0; k < dir_tab[r].rep; k++)
          send_slip(dir_tab[r].slip, dir_tab[r].back, dir_tab[r].prev, dir_tab[r].trial,
                    dir_tab[r].last, dir_tab[r].typed, dir_tab[r].exp_h, dir_tab[r].exp_f);
      end
    end

    // random grains; new settings every third grain, long hold-off early on
    for (int g = 0; n_items < 100; g++) begin
      if (g % 3 == 0) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_write(slipeu_pkg::CFG_HARDENING_RATE, rnd_reg(20));
        cfg_write(slipeu_pkg::CFG_INITIAL_HARD, rnd_reg(40));
        if ($urandom_range(0, 7) == 0) cfg_write(slipeu_pkg::CFG_SATURATION, 47'(r_tau0));
        else cfg_write(slipeu_pkg::CFG_SATURATION, rnd_reg(200));
        cfg_write(slipeu_pkg::CFG_COEFF_CS, rnd_reg(4));
        cfg_write(slipeu_pkg::CFG_COEFF_CX, ($urandom_range(0, 7) == 0) ? '0 : rnd_reg(4));
        cfg_write(slipeu_pkg::CFG_TIME_STEP, ($urandom_range(0, 9) == 0) ? '0 : rnd_reg(2));
        cfg_write(slipeu_pkg::CFG_UPDATE_MODE, 47'($urandom_range(0, 1)));
      end
      if (g == 1) hold_req = 1'b1;
      glen = ($urandom_range(0, 4) == 0) ? $urandom_range(5, SLIPS) : $urandom_range(1, 4);
      for (int k = 0; k < glen; k++)
        send_slip(rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                  (k == glen - 1) || ($urandom_range(0, 19) == 0), 1'b0, '0, 1'b0);
    end
    s_axis_tvalid <= 1'b0;

    while (hardness_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("run covered %0d slip requests in %0d grains, %0d hardness results",
             n_items, n_grains, n_results);
    $display("faults, saturation, count overflow, both modes and a long stall included");
    if (errors == 0 && hardness_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
